>>> rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// jsu_pkg: shared types and constants for the JSON string unescape block
// no dependencies

package jsu_pkg;

    // result queue depth, at least 4 so three results fit behind a waiting one
    localparam int QUEUE_DEPTH = 8;

    // characters with a meaning of their own
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    // utf-8 encoding
    localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;
    localparam logic [7:0]  UTF8_MASK6   = 8'h3F;

    // one result of the output channel
    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       last;
    } t_result;

    // everything one accepted request produces
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     res;
    } t_dec;

endpackage

>>> rtl/jsu_decode.sv
`timescale 1ns / 1ps
// jsu_decode: escape state, held \u characters and single-pass decode
// depends on jsu_pkg

module jsu_decode import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_string,
    output t_dec       o_dec
);

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_ESCAPE = 3'b010,
        PH_HEX    = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_held [3];
    logic [7:0] n_held [3];

    function automatic logic [7:0] map_escape(input logic [7:0] e);
        logic [7:0] m;
        case (e)
            CH_N:    m = 8'h0A;
            CH_R:    m = 8'h0D;
            CH_T:    m = 8'h09;
            CH_B:    m = 8'h08;
            CH_F:    m = 8'h0C;
            default: m = e;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end else begin
            d = 5'd0;
        end
        return d;
    endfunction

    logic [7:0]  bytes [3];
    logic [1:0]  k;
    logic [7:0]  q [4];
    logic [7:0]  t [3];
    logic [1:0]  tn;
    logic [15:0] cp;
    logic        stop;
    logic        esc;
    logic [4:0]  d;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_held  = r_held;
        bytes   = '{default: 8'd0};
        k       = 2'd0;
        cp      = 16'd0;
        stop    = 1'b0;
        esc     = 1'b0;
        d       = 5'd0;
        q       = '{r_held[0], r_held[1], r_held[2], i_char_in};
        t       = '{r_held[0], r_held[1], r_held[2]};
        tn      = r_cnt;

        unique case (r_phase)
            PH_ESCAPE: begin
                n_phase = PH_NORMAL;
                if (i_char_in == CH_U) begin
                    n_phase = PH_HEX;
                    n_cnt   = 2'd0;
                end else begin
                    bytes[0] = map_escape(i_char_in);
                    k        = 2'd1;
                end
            end
            PH_HEX: begin
                if (r_cnt == 2'd3) begin
                    // code point from the leading run of hex digits
                    for (int j = 0; j < 4; j++) begin
                        d = hex_digit(q[j]);
                        if (!stop && d[4]) begin
                            cp = {cp[11:0], d[3:0]};
                        end else begin
                            stop = 1'b1;
                        end
                    end
                    if (cp < CP_ONE_LIMIT) begin
                        bytes[0] = cp[7:0];
                        k        = 2'd1;
                    end else if (cp < CP_TWO_LIMIT) begin
                        bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
                        bytes[1] = UTF8_CONT | (cp[7:0] & UTF8_MASK6);
                        k        = 2'd2;
                    end else begin
                        bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
                        bytes[1] = UTF8_CONT | (cp[13:6] & UTF8_MASK6);
                        bytes[2] = UTF8_CONT | (cp[7:0] & UTF8_MASK6);
                        k        = 2'd3;
                    end
                    n_phase = PH_NORMAL;
                    n_cnt   = 2'd0;
                end else if (i_end_of_string) begin
                    // short \u at end: replay held characters as plain input
                    t[r_cnt] = i_char_in;
                    for (int j = 0; j < 3; j++) begin
                        if (2'(j) <= tn) begin
                            if (esc) begin
                                esc = 1'b0;
                                if (t[j] != CH_U) begin
                                    bytes[k] = map_escape(t[j]);
                                    k        = k + 2'd1;
                                end
                            end else if (t[j] == CH_BSLASH) begin
                                esc = 1'b1;
                            end else begin
                                bytes[k] = t[j];
                                k        = k + 2'd1;
                            end
                        end
                    end
                end else begin
                    n_held[r_cnt] = i_char_in;
                    n_cnt         = r_cnt + 2'd1;
                end
            end
            default: begin
                if (i_char_in == CH_BSLASH) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    bytes[0] = i_char_in;
                    k        = 2'd1;
                end
            end
        endcase

        if (i_end_of_string) begin
            n_phase = PH_NORMAL;
            n_cnt   = 2'd0;
        end
    end

    always_comb begin
        o_dec = '0;
        if (i_end_of_string && k == 2'd0) begin
            o_dec.cnt    = 2'd1;
            o_dec.res[0] = '{byte_out: 8'd0, byte_valid: 1'b0, last: 1'b1};
        end else begin
            o_dec.cnt = k;
            for (int j = 0; j < 3; j++) begin
                o_dec.res[j].byte_out   = bytes[j];
                o_dec.res[j].byte_valid = 1'b1;
                o_dec.res[j].last       = i_end_of_string && (2'(j + 1) == k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_cnt   <= 2'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

>>> rtl/jsu_outq.sv
`timescale 1ns / 1ps
// jsu_outq: result queue, takes up to three results a cycle, gives one while i_stall is low
// depends on jsu_pkg

module jsu_outq import jsu_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_dec    i_dec,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    push_cnt;
    logic          pop;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] off);
        logic [PW:0] s;
        s = {1'b0, p} + {{(PW-1){1'b0}}, off};
        if (s >= (PW+1)'(DEPTH)) begin
            s = s - (PW+1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    assign push_cnt = i_push ? i_dec.cnt : 2'd0;
    assign pop      = o_valid && !i_stall;
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd];
    assign o_room   = (r_count <= CW'(DEPTH - 3));

    always_comb begin
        n_wr    = wrap_add(r_wr, push_cnt);
        n_rd    = pop ? wrap_add(r_rd, 2'd1) : r_rd;
        n_count = r_count + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < push_cnt) begin
                r_mem[wrap_add(r_wr, 2'(j))] <= i_dec.res[j];
            end
        end
    end

endmodule

>>> rtl/json_string_unescape.sv
`timescale 1ns / 1ps
// json_string_unescape: streaming decoder for the body of a JSON string
// depends on jsu_pkg, jsu_decode, jsu_outq
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_char_in, i_end_of_string
//   output   out        o_valid / i_stall  o_byte_out, o_byte_valid, o_last
//
// one request is decoded in the cycle it is accepted; its results are registered
// into the queue and reach the output behind any results already queued.
// a request may be accepted every cycle while o_stall is low; each gives zero to three results.
// o_stall rises while the result queue has fewer than three free entries.
// synchronous active-low reset empties the queue and returns to plain text.

module json_string_unescape import jsu_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic       o_byte_valid,
    output logic       o_last
);

    t_dec    dec;
    t_result res;
    logic    room;
    logic    accept;

    assign o_stall = !room;
    assign accept  = i_valid && room;

    jsu_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_char_in       (i_char_in),
        .i_end_of_string (i_end_of_string),
        .o_dec           (dec)
    );

    jsu_outq #(
        .DEPTH (QDEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_dec    (dec),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (res)
    );

    assign o_byte_out   = res.byte_out;
    assign o_byte_valid = res.byte_valid;
    assign o_last       = res.last;

endmodule

>>> rtl/jsu_checker.sv
`timescale 1ns / 1ps
// jsu_checker: port-level checks for json_string_unescape, bound to the top
// depends on json_string_unescape

module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_char_in,
    input logic       i_end_of_string,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_byte_out,
    input logic       o_byte_valid,
    input logic       o_last
);

    // stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_char_in)
            && $stable(i_end_of_string))
        else $error("stalled request changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_byte_out)
            && $stable(o_byte_valid) && $stable(o_last))
        else $error("stalled result changed");

    // an empty marker only closes a string
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_last)
        else $error("empty result not marked last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_byte_out == 8'd0)
        else $error("empty result carries a byte");

    // with nothing queued the input must be open
    a_idle_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty queue");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_char_in       (i_char_in),
    .i_end_of_string (i_end_of_string),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_byte_out      (o_byte_out),
    .o_byte_valid    (o_byte_valid),
    .o_last          (o_last)
);
